@@ rtl/core/stbs_pkg.sv @@
// ----------------------------------------------------------------------------
// stbs_pkg - shared types and constants for the sorted table search block
// Table geometry, field widths, result codes and the control/status bundles
// that run between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int KEY_W   = 15;
   localparam int MODE_W  = 8;
   localparam int ENTRY_W = KEY_W + 2 * MODE_W;
   localparam int STAT_W  = 2;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [CNT_W:0]   sum_type;

   // request kind
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

   // read address select
   localparam logic [1:0] RD_CACHE = 2'd0;
   localparam logic [1:0] RD_INIT  = 2'd1;
   localparam logic [1:0] RD_STEP  = 2'd2;

   // result select
   localparam logic [2:0] RSEL_LOAD_OK = 3'd0;
   localparam logic [2:0] RSEL_FULL    = 3'd1;
   localparam logic [2:0] RSEL_EMPTY   = 3'd2;
   localparam logic [2:0] RSEL_HIT     = 3'd3;
   localparam logic [2:0] RSEL_MISS    = 3'd4;

   typedef struct packed {
      logic       capture;
      logic       write_entry;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       res_load;
      logic [2:0] res_sel;
      logic       push;
   } stbs_cmd_type;

   typedef struct packed {
      logic is_load;
      logic full;
      logic empty;
      logic cache_ok;
      logic key_eq;
      logic exhausted;
      logic rsp_free;
   } stbs_sts_type;

endpackage

`default_nettype wire

@@ rtl/core/stbs_ram.sv @@
// ----------------------------------------------------------------------------
// stbs_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire  [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire  [WIDTH-1:0]          wr_data,
   input  wire                       rd_en,
   input  wire  [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/stbs_datapath.sv @@
// ----------------------------------------------------------------------------
// stbs_datapath - table storage, search window and result registers
// Holds the entry RAM, fill count, last-hit register, the binary search
// bounds and the output register of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_datapath (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_tuser,
   input  wire  [31:0]                   req_tdata,
   input  wire                           rsp_tready,
   output logic                          rsp_tvalid,
   output logic [23:0]                   rsp_tdata,
   output logic [1:0]                    rsp_tuser,
   input  wire  stbs_pkg::stbs_cmd_type  cmd,
   output stbs_pkg::stbs_sts_type        sts
);

   // captured request
   logic                             func_ff;
   logic [stbs_pkg::KEY_W-1:0]       key_ff;
   logic [stbs_pkg::MODE_W-1:0]      cm_ff;
   logic [stbs_pkg::MODE_W-1:0]      em_ff;

   // table state
   stbs_pkg::cnt_type                count_ff;
   logic                             lh_valid_ff;
   stbs_pkg::idx_type                lh_index_ff;

   // search window: low inclusive, hiex exclusive
   stbs_pkg::cnt_type                low_ff, low_in;
   stbs_pkg::cnt_type                hiex_ff, hiex_in;
   stbs_pkg::idx_type                mid_ff;
   stbs_pkg::idx_type                mid_init, mid_step;
   stbs_pkg::sum_type                sum_init, sum_step;

   // pending result
   logic [stbs_pkg::STAT_W-1:0]      res_status_ff, res_status_in;
   logic [7:0]                       res_index_ff, res_index_in;
   logic [stbs_pkg::MODE_W-1:0]      res_cm_ff, res_cm_in;
   logic [stbs_pkg::MODE_W-1:0]      res_em_ff, res_em_in;

   logic                             rsp_valid_ff;
   logic [23:0]                      rsp_data_ff;
   logic [1:0]                       rsp_user_ff;

   logic [stbs_pkg::ENTRY_W-1:0]     rd_data;
   logic [stbs_pkg::ENTRY_W-1:0]     wr_data;
   stbs_pkg::idx_type                rd_addr;
   logic [stbs_pkg::KEY_W-1:0]       rd_key;
   logic                             key_lt;
   logic [stbs_pkg::IDX_W+7:0]       mid_ext, cnt_ext;

   // entry layout: key low, error mode, collision mode high
   assign wr_data = {cm_ff, em_ff, key_ff};
   assign rd_key  = rd_data[stbs_pkg::KEY_W-1:0];

   stbs_ram #(
      .WIDTH (stbs_pkg::ENTRY_W),
      .DEPTH (stbs_pkg::TABLE_DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (cmd.write_entry),
      .wr_addr (stbs_pkg::idx_type'(count_ff)),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next search window from the entry at mid_ff
   always_comb begin
      key_lt   = key_ff < rd_key;
      low_in   = low_ff;
      hiex_in  = hiex_ff;
      if (key_lt) begin
         hiex_in = stbs_pkg::cnt_type'(mid_ff);
      end else begin
         low_in = stbs_pkg::cnt_type'(mid_ff) + stbs_pkg::cnt_type'(1);
      end
      sum_init = stbs_pkg::sum_type'(count_ff) - stbs_pkg::sum_type'(1);
      sum_step = stbs_pkg::sum_type'(low_in) + stbs_pkg::sum_type'(hiex_in)
                 - stbs_pkg::sum_type'(1);
      mid_init = sum_init[stbs_pkg::IDX_W:1];
      mid_step = sum_step[stbs_pkg::IDX_W:1];
   end

   always_comb begin
      unique case (cmd.rd_sel)
         stbs_pkg::RD_CACHE: rd_addr = lh_index_ff;
         stbs_pkg::RD_INIT:  rd_addr = mid_init;
         default:            rd_addr = mid_step;
      endcase
   end

   assign mid_ext = {8'd0, mid_ff};
   assign cnt_ext = {8'd0, stbs_pkg::idx_type'(count_ff)};

   always_comb begin
      res_status_in = stbs_pkg::ST_OK;
      res_index_in  = 8'd0;
      res_cm_in     = '0;
      res_em_in     = '0;
      unique case (cmd.res_sel)
         stbs_pkg::RSEL_LOAD_OK: begin
            res_index_in = cnt_ext[7:0];
            res_cm_in    = cm_ff;
            res_em_in    = em_ff;
         end
         stbs_pkg::RSEL_FULL:  res_status_in = stbs_pkg::ST_FULL;
         stbs_pkg::RSEL_EMPTY: res_status_in = stbs_pkg::ST_EMPTY;
         stbs_pkg::RSEL_HIT: begin
            res_index_in = mid_ext[7:0];
            res_cm_in    = rd_data[stbs_pkg::ENTRY_W-1 -: stbs_pkg::MODE_W];
            res_em_in    = rd_data[stbs_pkg::KEY_W +: stbs_pkg::MODE_W];
         end
         default: res_status_in = stbs_pkg::ST_NOT_FOUND;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         lh_valid_ff  <= 1'b0;
         lh_index_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.write_entry) begin
            count_ff <= count_ff + stbs_pkg::cnt_type'(1);
         end
         if (cmd.res_load && cmd.res_sel == stbs_pkg::RSEL_HIT) begin
            lh_valid_ff <= 1'b1;
            lh_index_ff <= mid_ff;
         end
         if (cmd.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_tuser;
         key_ff  <= req_tdata[14:0];
         cm_ff   <= req_tdata[22:15];
         em_ff   <= req_tdata[30:23];
      end
      if (cmd.rd_en) begin
         unique case (cmd.rd_sel)
            stbs_pkg::RD_CACHE: mid_ff <= lh_index_ff;
            stbs_pkg::RD_INIT: begin
               low_ff  <= '0;
               hiex_ff <= count_ff;
               mid_ff  <= mid_init;
            end
            default: begin
               low_ff  <= low_in;
               hiex_ff <= hiex_in;
               mid_ff  <= mid_step;
            end
         endcase
      end
      if (cmd.res_load) begin
         res_status_ff <= res_status_in;
         res_index_ff  <= res_index_in;
         res_cm_ff     <= res_cm_in;
         res_em_ff     <= res_em_in;
      end
      if (cmd.push) begin
         rsp_data_ff <= {res_em_ff, res_cm_ff, res_index_ff};
         rsp_user_ff <= res_status_ff;
      end
   end

   assign sts.is_load   = func_ff == stbs_pkg::FUNC_LOAD;
   assign sts.full      = count_ff == stbs_pkg::cnt_type'(stbs_pkg::TABLE_DEPTH);
   assign sts.empty     = count_ff == '0;
   assign sts.cache_ok  = lh_valid_ff && (stbs_pkg::cnt_type'(lh_index_ff) < count_ff);
   assign sts.key_eq    = key_ff == rd_key;
   assign sts.exhausted = low_in >= hiex_in;
   assign sts.rsp_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

@@ rtl/core/stbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// stbs_ctrl - request sequencer
// Steps one request through dispatch, last-hit check, probe loop and
// hand-off to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_ctrl (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_tvalid,
   output logic                          req_tready,
   input  wire  stbs_pkg::stbs_sts_type  sts,
   output stbs_pkg::stbs_cmd_type        cmd
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DISPATCH  = 3'd1;
   localparam logic [2:0] S_CACHE_CMP = 3'd2;
   localparam logic [2:0] S_PROBE     = 3'd3;
   localparam logic [2:0] S_FINISH    = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_tready = state_ff == S_IDLE;

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.rd_sel      = stbs_pkg::RD_INIT;
      cmd.res_sel     = stbs_pkg::RSEL_MISS;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (sts.is_load) begin
               cmd.write_entry = !sts.full;
               cmd.res_load    = 1'b1;
               cmd.res_sel     = sts.full ? stbs_pkg::RSEL_FULL : stbs_pkg::RSEL_LOAD_OK;
               state_in        = S_FINISH;
            end else if (sts.empty) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = stbs_pkg::RSEL_EMPTY;
               state_in     = S_FINISH;
            end else if (sts.cache_ok) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = stbs_pkg::RD_CACHE;
               state_in   = S_CACHE_CMP;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = stbs_pkg::RD_INIT;
               state_in   = S_PROBE;
            end
         end
         S_CACHE_CMP: begin
            if (sts.key_eq) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = stbs_pkg::RSEL_HIT;
               state_in     = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = stbs_pkg::RD_INIT;
               state_in   = S_PROBE;
            end
         end
         S_PROBE: begin
            priority if (sts.key_eq) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = stbs_pkg::RSEL_HIT;
               state_in     = S_FINISH;
            end else if (sts.exhausted) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = stbs_pkg::RSEL_MISS;
               state_in     = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = stbs_pkg::RD_STEP;
            end
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/sorted_table_binary_search.sv @@
// ----------------------------------------------------------------------------
// sorted_table_binary_search - sorted key table with last-hit lookup cache
// Appends (key, modes) entries and looks keys up by binary search.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser = func (0 load, 1 lookup); tdata = key, collision
//   mode, error mode. One request at a time; req_tready is high while idle.
//   rsp channel: one result per request; tuser = status, tdata = entry
//   index and both modes (zero unless the entry was stored or found).
// Steps, from acceptance until rsp_tvalid rises:
//   load, table empty or table full: dispatch, then finish
//   lookup that hits the last-hit entry: dispatch, last-hit check, finish
//   lookup that searches: dispatch, p probes, finish; p is at most
//   ceil(log2(entries + 1)), so up to 9 at 256 entries, with the last-hit
//   check before them when it was tried first and missed.
//   The probe loop does one entry RAM read and one key compare per
//   cycle. A new request is taken the cycle after its result is handed to
//   the output register.
// Reset clears the entry count and the last-hit register; the RAM itself
//   is not cleared and only loaded positions are ever read.
// A stalled result sits in the output register; the next request is still
//   accepted and processed, then waits in the finish step until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [14:0] key, [22:15] collision_mode_in,
                                    // [30:23] error_mode_in, [31] zero
   input  wire         req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] entry_index,
                                    // [15:8] collision_mode_out,
                                    // [23:16] error_mode_out
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   stbs_pkg::stbs_cmd_type cmd;
   stbs_pkg::stbs_sts_type sts;

   stbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   stbs_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

   // a request in flight blocks the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a previous one is in flight");

   // never store past the end of the table
   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.write_entry |-> !sts.full)
      else $error("entry written into a full table");

   // the output register is only loaded when it is free
   a_push_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> sts.rsp_free)
      else $error("pending result overwritten");

   // every non-ok status carries zero payload
   a_fail_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != stbs_pkg::ST_OK) |-> rsp_tdata == 24'd0)
      else $error("failed request returned nonzero payload");

endmodule

`default_nettype wire

@@ tb/sv/sorted_table_binary_search_checker.sv @@
// ----------------------------------------------------------------------------
// sorted_table_binary_search_checker - result checker for the table search
// Watches the request and response streams, keeps its own copy of the key
// table and the last-hit register, and compares every response with the
// answer predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_checker
   import stbs_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [31:0] req_tdata,   // [14:0] key, [22:15] collision mode, [30:23] error mode
   input  wire         req_tuser,   // [0] func
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [23:0] rsp_tdata,   // [7:0] index, [15:8] collision mode, [23:16] error mode
   input  wire  [1:0]  rsp_tuser,   // [1:0] status
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [7:0]        index;
      logic [MODE_W-1:0] cmode;
      logic [MODE_W-1:0] emode;
   } lookup_answer_type;

   logic [KEY_W-1:0]    key_store  [TABLE_DEPTH];
   logic [2*MODE_W-1:0] mode_store [TABLE_DEPTH];
   int                  entries_held;
   bit                  last_hit_ok;
   int                  last_hit_pos;
   lookup_answer_type   answers_due [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      entries_held  = 0;
      last_hit_ok   = 1'b0;
      last_hit_pos  = 0;
   end

   // append or search, updating the shadow table
   function automatic lookup_answer_type append_or_search(logic func, logic [KEY_W-1:0] key,
                                                          logic [MODE_W-1:0] cm,
                                                          logic [MODE_W-1:0] em);
      lookup_answer_type ans;
      int lo;
      int hi;
      int mid;
      bit found;
      ans   = '0;
      found = 1'b0;
      if (func == FUNC_LOAD) begin
         if (entries_held >= TABLE_DEPTH) begin
            ans.status = ST_FULL;
         end else begin
            key_store[entries_held]  = key;
            mode_store[entries_held] = {cm, em};
            ans.status = ST_OK;
            ans.index  = 8'(entries_held);
            ans.cmode  = cm;
            ans.emode  = em;
            entries_held++;
         end
      end else if (entries_held == 0) begin
         ans.status = ST_EMPTY;
      end else if (last_hit_ok && last_hit_pos < entries_held &&
                   key_store[last_hit_pos] == key) begin
         ans.status = ST_OK;
         ans.index  = 8'(last_hit_pos);
         {ans.cmode, ans.emode} = mode_store[last_hit_pos];
      end else begin
         ans.status = ST_NOT_FOUND;
         lo = 0;
         hi = entries_held - 1;
         while (!found && lo <= hi) begin
            mid = (lo + hi) / 2;
            if (key < key_store[mid]) begin
               hi = mid - 1;
            end else if (key > key_store[mid]) begin
               lo = mid + 1;
            end else begin
               found        = 1'b1;
               last_hit_ok  = 1'b1;
               last_hit_pos = mid;
               ans.status   = ST_OK;
               ans.index    = 8'(mid);
               {ans.cmode, ans.emode} = mode_store[mid];
            end
         end
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      lookup_answer_type want;
      lookup_answer_type seen;
      if (!reset) begin
         if (req_tvalid && req_tready)
            answers_due.push_back(append_or_search(req_tuser, req_tdata[14:0],
                                                   req_tdata[22:15], req_tdata[30:23]));
         if (rsp_tvalid && rsp_tready) begin
            seen = {rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16]};
            if (answers_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("[%0t] unexpected response: st=%0d idx=%0d cm=%0h em=%0h",
                           $realtime, seen.status, seen.index, seen.cmode, seen.emode);
            end else begin
               want = answers_due.pop_front();
               if (seen.status !== want.status || seen.index !== want.index ||
                   seen.cmode !== want.cmode || seen.emode !== want.emode) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("[%0t] mismatch: exp st=%0d idx=%0d cm=%0h em=%0h,",
                              $realtime, want.status, want.index, want.cmode,
                              want.emode,
                              " got st=%0d idx=%0d cm=%0h em=%0h",
                              seen.status, seen.index, seen.cmode, seen.emode);
               end
            end
         end
      end
      pending_count = answers_due.size();
   end

endmodule

@@ tb/sv/sorted_table_binary_search_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_table_binary_search_tb - testbench top for the sorted table search
// Drives load and lookup requests (directed corner cases, then ascending
// table builds with random lookups, duplicates and out-of-order loads) under
// three idle profiles and one long response stall; the checker predicts.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_tb;
   import stbs_pkg::*;

   localparam int CLK_HALF     = 6;
   localparam int RESET_CYCLES = 11;
   localparam int PHASE_ITEMS  = 630;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 30;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [14:0] key, [22:15] collision mode, [30:23] error mode
   logic        req_tuser;   // [0] func
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [7:0] index, [15:8] collision mode, [23:16] error mode
   logic [1:0]  rsp_tuser;   // [1:0] status

   int fail_count;
   int pending_count;
   int cycle_count;

   // idle profiles, in percent of cycles
   int send_idle_pct;
   int recv_idle_pct;

   // long response stall: stimulus bumps the request count, receiver serves it
   int hold_requests;
   int holds_served;

   // stimulus-side view of the table, used only to pick keys
   int               entries_sent;
   int               top_key;
   logic [KEY_W-1:0] loaded_keys [$];
   logic [KEY_W-1:0] recent_key;

   sorted_table_binary_search uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   sorted_table_binary_search_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // response side: random backpressure, plus the long stall on demand
   initial begin
      int n;
      rsp_tready   = 1'b0;
      holds_served = 0;
      @(negedge clock);
      forever begin
         if (holds_served < hold_requests) begin
            holds_served++;
            rsp_tready = 1'b0;
            // hold off while the sender keeps pushing, so the block backs up
            for (n = 0; n < HOLD_CYCLES; n++)
               @(negedge clock);
         end else begin
            rsp_tready = ($urandom_range(0, 99) >= recv_idle_pct);
            @(negedge clock);
         end
      end
   end

   // one request; called and returns at a falling edge
   task automatic send_request(logic func, logic [KEY_W-1:0] key,
                               logic [MODE_W-1:0] cm, logic [MODE_W-1:0] em);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = func;
      req_tdata  = {1'b0, em, cm, key};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_entry(logic [KEY_W-1:0] key, logic [MODE_W-1:0] cm,
                             logic [MODE_W-1:0] em);
      if (entries_sent < TABLE_DEPTH) begin
         loaded_keys.push_back(key);
         entries_sent++;
      end
      send_request(FUNC_LOAD, key, cm, em);
   endtask

   task automatic lookup_key(logic [KEY_W-1:0] key);
      recent_key = key;
      send_request(FUNC_LOOKUP, key, MODE_W'($urandom_range(0, 255)),
                   MODE_W'($urandom_range(0, 255)));
   endtask

   // Mostly ascending loads and lookups of stored keys; some duplicates,
   // neighbors, random misses and out-of-order loads as noise. Once the table
   // is full, loads become rare and all report table full.
   task automatic send_random_request();
      int pick;
      int nxt;
      logic [KEY_W-1:0] key;
      pick = $urandom_range(0, 99);
      if (pick < ((entries_sent < TABLE_DEPTH) ? 35 : 8)) begin
         if ($urandom_range(0, 99) < 4) begin
            key = KEY_W'($urandom_range(0, 32767));     // out of order
         end else if (entries_sent == TABLE_DEPTH - 1) begin
            key = '1;                                  // last slot gets the top key
         end else begin
            nxt = top_key + $urandom_range(0, 127);    // step 0 makes a duplicate
            if (nxt > 32766)
               nxt = 32766;
            top_key = nxt;
            key = KEY_W'(nxt);
         end
         load_entry(key, MODE_W'($urandom_range(0, 255)), MODE_W'($urandom_range(0, 255)));
      end else begin
         pick = $urandom_range(0, 99);
         if (loaded_keys.size() == 0 || pick < 20)
            key = KEY_W'($urandom_range(0, 32767));
         else if (pick < 40)
            key = recent_key;                          // repeat: last-hit path
         else if (pick < 85)
            key = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
         else if (pick < 93)
            key = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)] + 1'b1;
         else
            key = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)] - 1'b1;
         lookup_key(key);
      end
   endtask

   initial begin
      int i;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = FUNC_LOAD;
      reset         = 1'b1;
      send_idle_pct = 22;
      recv_idle_pct = 63;
      hold_requests = 0;
      entries_sent  = 0;
      top_key       = 0;
      recent_key    = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty table, extremes, duplicates, cache hit, misses
      lookup_key('0);
      lookup_key('1);
      load_entry('0, 8'h00, 8'h00);
      load_entry(15'd5, 8'hff, 8'hff);
      load_entry(15'd5, 8'h5a, 8'ha5);
      load_entry(15'd100, 8'h81, 8'h18);
      top_key = 100;
      lookup_key('0);
      lookup_key('0);                 // served by the last-hit register
      lookup_key(15'd100);
      lookup_key(15'd5);
      lookup_key(15'd3);              // miss, last hit kept
      lookup_key(15'd5);
      lookup_key('1);                 // above every key
      lookup_key(15'd100);

      // phase 1: sender idles a little, receiver a lot
      for (i = 0; i < PHASE_ITEMS; i++)
         send_random_request();

      // phase 2: the other way round
      send_idle_pct = 63;
      recv_idle_pct = 22;
      for (i = 0; i < PHASE_ITEMS; i++)
         send_random_request();

      // phase 3: no idling, opened by one long response stall
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests = 1;
      for (i = 0; i < PHASE_ITEMS; i++)
         send_random_request();

      req_tvalid = 1'b0;
      while (pending_count != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
